[hdl/sdspi_pkg.sv]
// ----------------------------------------------------------------------------
// sdspi_pkg
// Types, constants and the command table for the SD card SPI command engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sdspi_pkg;

	localparam int unsigned CmdCount = 20;
	localparam logic [4:0] StopIndex = 5'd5;
	localparam logic [7:0] IdleByte = 8'hFF;
	localparam logic [1:0] CmdPrefix = 2'b01;
	localparam logic [2:0] LastSendPos = 3'd5;
	localparam logic [2:0] LastCollectPos = 3'd3;
	localparam logic [7:0] RespLimitReset = 8'd20;
	localparam logic [19:0] BusyLimitReset = 20'hA0000;

	localparam logic CfgRespLimit = 1'b0;
	localparam logic CfgBusyLimit = 1'b1;

	typedef enum logic [7:0] {
		PH_IDLE    = 8'b0000_0001,
		PH_SEND    = 8'b0000_0010,
		PH_DUMMY   = 8'b0000_0100,
		PH_POLL    = 8'b0000_1000,
		PH_SECOND  = 8'b0001_0000,
		PH_BUSY    = 8'b0010_0000,
		PH_COLLECT = 8'b0100_0000,
		PH_TRAIL   = 8'b1000_0000
	} phase_t;

	typedef enum logic [2:0] {
		RT_R1  = 3'd0,
		RT_R1B = 3'd1,
		RT_R2  = 3'd2,
		RT_R3  = 3'd3,
		RT_R7  = 3'd4
	} rtype_t;

	typedef struct packed {
		logic [5:0] code;
		logic [7:0] crc;
		rtype_t     rtype;
		logic       data;
	} cmd_info_t;

	typedef struct packed {
		phase_t      phase;
		logic [2:0]  byte_pos;
		logic [19:0] wait_count;
		logic [4:0]  active_cmd;
		logic [31:0] arg;
		logic [7:0]  first_status;
		logic [7:0]  second_status;
		logic [31:0] payload;
		logic        sel_held;
	} eng_state_t;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        chip_select;
		logic        done_res;
		logic [7:0]  status_first;
		logic [7:0]  status_second;
		logic [31:0] payload;
		logic        busy_res;
	} eng_result_t;

	function automatic cmd_info_t cmd_entry(input logic [4:0] idx);
		cmd_info_t e;
		case (idx)
			5'd0:  e = '{6'd0,  8'h95, RT_R1,  1'b0};
			5'd1:  e = '{6'd1,  8'hF9, RT_R1,  1'b0};
			5'd2:  e = '{6'd8,  8'h87, RT_R7,  1'b0};
			5'd3:  e = '{6'd9,  8'hAF, RT_R1,  1'b1};
			5'd4:  e = '{6'd10, 8'h1B, RT_R1,  1'b1};
			5'd5:  e = '{6'd12, 8'hC3, RT_R1B, 1'b0};
			5'd6:  e = '{6'd13, 8'hAF, RT_R2,  1'b0};
			5'd7:  e = '{6'd16, 8'hFF, RT_R1,  1'b0};
			5'd8:  e = '{6'd17, 8'hFF, RT_R1,  1'b1};
			5'd9:  e = '{6'd18, 8'hFF, RT_R1,  1'b1};
			5'd10: e = '{6'd23, 8'hFF, RT_R1,  1'b0};
			5'd11: e = '{6'd24, 8'hFF, RT_R1,  1'b1};
			5'd12: e = '{6'd25, 8'hFF, RT_R1,  1'b1};
			5'd13: e = '{6'd32, 8'hFF, RT_R1,  1'b0};
			5'd14: e = '{6'd33, 8'hFF, RT_R1,  1'b0};
			5'd15: e = '{6'd38, 8'hDF, RT_R1B, 1'b0};
			5'd16: e = '{6'd41, 8'hFF, RT_R3,  1'b0};
			5'd17: e = '{6'd55, 8'h73, RT_R1,  1'b0};
			5'd18: e = '{6'd58, 8'h25, RT_R7,  1'b0};
			5'd19: e = '{6'd59, 8'h25, RT_R1,  1'b0};
			default: e = '{6'd0, 8'h95, RT_R1, 1'b0};
		endcase
		return e;
	endfunction

endpackage

`default_nettype wire

[hdl/sdspi_step.sv]
// ----------------------------------------------------------------------------
// sdspi_step
// Next-state and result logic for one transaction of the command engine.
// ----------------------------------------------------------------------------
`default_nettype none

module sdspi_step (
	input  var sdspi_pkg::eng_state_t  cur,
	input  wire                        cmd,
	input  wire [4:0]                  command_index,
	input  wire [31:0]                 argument,
	input  wire [7:0]                  rx_byte,
	input  wire [7:0]                  resp_limit,
	input  wire [19:0]                 busy_limit,
	output sdspi_pkg::eng_state_t      nxt,
	output sdspi_pkg::eng_result_t     res
);

	sdspi_pkg::cmd_info_t cur_info;
	sdspi_pkg::cmd_info_t nxt_info;
	logic                 done;
	logic [7:0]           poll_dec;
	logic [19:0]          busy_dec;
	logic [7:0]           tx;

	assign cur_info = sdspi_pkg::cmd_entry(cur.active_cmd);
	assign nxt_info = sdspi_pkg::cmd_entry(nxt.active_cmd);
	assign poll_dec = cur.wait_count[7:0] - 8'd1;
	assign busy_dec = cur.wait_count - 20'd1;

	always_comb begin
		nxt  = cur;
		done = 1'b0;
		if (!cmd) begin
			if (command_index < 5'(sdspi_pkg::CmdCount)) begin
				nxt.active_cmd    = command_index;
				nxt.arg           = argument;
				nxt.phase         = sdspi_pkg::PH_SEND;
				nxt.byte_pos      = 3'd0;
				nxt.wait_count    = 20'd0;
				nxt.first_status  = sdspi_pkg::IdleByte;
				nxt.second_status = 8'd0;
				nxt.payload       = 32'd0;
				nxt.sel_held      = 1'b1;
			end
		end else begin
			case (cur.phase)
				sdspi_pkg::PH_IDLE: begin
					nxt.phase = sdspi_pkg::PH_IDLE;
				end
				sdspi_pkg::PH_SEND: begin
					if (cur.byte_pos < sdspi_pkg::LastSendPos) begin
						nxt.byte_pos = cur.byte_pos + 3'd1;
					end else begin
						nxt.byte_pos   = 3'd0;
						nxt.wait_count = {12'd0, resp_limit};
						nxt.phase      = (cur.active_cmd == sdspi_pkg::StopIndex) ?
						                 sdspi_pkg::PH_DUMMY : sdspi_pkg::PH_POLL;
					end
				end
				sdspi_pkg::PH_DUMMY: begin
					nxt.phase = sdspi_pkg::PH_POLL;
				end
				sdspi_pkg::PH_POLL: begin
					nxt.first_status = rx_byte;
					nxt.wait_count   = {12'd0, poll_dec};
					if (!(rx_byte == sdspi_pkg::IdleByte && poll_dec != 8'd0)) begin
						case (cur_info.rtype)
							sdspi_pkg::RT_R2: nxt.phase = sdspi_pkg::PH_SECOND;
							sdspi_pkg::RT_R1B: begin
								nxt.phase      = sdspi_pkg::PH_BUSY;
								nxt.wait_count = busy_limit;
							end
							sdspi_pkg::RT_R3, sdspi_pkg::RT_R7: begin
								nxt.phase    = sdspi_pkg::PH_COLLECT;
								nxt.byte_pos = 3'd0;
							end
							default: nxt.phase = sdspi_pkg::PH_TRAIL;
						endcase
					end
				end
				sdspi_pkg::PH_SECOND: begin
					nxt.second_status = rx_byte;
					nxt.phase         = sdspi_pkg::PH_TRAIL;
				end
				sdspi_pkg::PH_BUSY: begin
					nxt.wait_count = busy_dec;
					if (!(rx_byte == 8'd0 && busy_dec != 20'd0)) begin
						nxt.first_status = 8'd0;
						nxt.phase        = sdspi_pkg::PH_TRAIL;
					end
				end
				sdspi_pkg::PH_COLLECT: begin
					nxt.payload = {cur.payload[23:0], rx_byte};
					if (cur.byte_pos >= sdspi_pkg::LastCollectPos) begin
						nxt.byte_pos = 3'd0;
						nxt.phase    = sdspi_pkg::PH_TRAIL;
					end else begin
						nxt.byte_pos = cur.byte_pos + 3'd1;
					end
				end
				sdspi_pkg::PH_TRAIL: begin
					nxt.phase    = sdspi_pkg::PH_IDLE;
					nxt.sel_held = cur_info.data;
					done         = 1'b1;
				end
				default: begin
					nxt.phase = sdspi_pkg::PH_IDLE;
				end
			endcase
		end
	end

	// byte to put on the bus next, taken from the updated state
	always_comb begin
		tx = sdspi_pkg::IdleByte;
		if (nxt.phase == sdspi_pkg::PH_SEND) begin
			case (nxt.byte_pos)
				3'd0: tx = {sdspi_pkg::CmdPrefix, nxt_info.code};
				3'd1: tx = nxt.arg[31:24];
				3'd2: tx = nxt.arg[23:16];
				3'd3: tx = nxt.arg[15:8];
				3'd4: tx = nxt.arg[7:0];
				default: tx = nxt_info.crc;
			endcase
		end
	end

	always_comb begin
		res.tx_valid      = (nxt.phase != sdspi_pkg::PH_IDLE);
		res.tx_byte       = tx;
		res.chip_select   = nxt.sel_held;
		res.done_res      = done;
		res.status_first  = nxt.first_status;
		res.status_second = nxt.second_status;
		res.payload       = nxt.payload;
		res.busy_res      = (nxt.phase != sdspi_pkg::PH_IDLE);
	end

endmodule

`default_nettype wire

[hdl/sd_spi_command_engine_top.sv]
// The state update is a single registered pass; results go to the output register.
// Throughput: one transaction per cycle unless a held result stalls the input.
// Input is taken while the result register is empty or being read in the same cycle.
// Reset (arst_n low, asynchronous): engine idle, held select cleared, result empty,
// response limit 20 and busy limit 0xA0000.
// ----------------------------------------------------------------------------
// sd_spi_command_engine_top
// Host side of one SD card SPI-mode command, one byte exchange per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module sd_spi_command_engine_top (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  wire        cfg_index,
	input  wire [19:0] cfg_data,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire        cmd,
	input  wire [4:0]  command_index,
	input  wire [31:0] argument,
	input  wire [7:0]  rx_byte,
	output logic       out_valid,
	input  wire        out_ready,
	output logic       tx_valid,
	output logic [7:0] tx_byte,
	output logic       chip_select,
	output logic       done_res,
	output logic [7:0] status_first,
	output logic [7:0] status_second,
	output logic [31:0] payload,
	output logic       busy_res
);

	logic [7:0]             resp_limit_q;
	logic [19:0]            busy_limit_q;
	sdspi_pkg::eng_state_t  state_q;
	sdspi_pkg::eng_state_t  state_nxt;
	sdspi_pkg::eng_result_t res_nxt;
	sdspi_pkg::eng_result_t res_q;
	logic                   res_valid_q;
	logic                   in_fire;

	assign in_ready = !res_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resp_limit_q <= sdspi_pkg::RespLimitReset;
			busy_limit_q <= sdspi_pkg::BusyLimitReset;
		end else if (cfg_we) begin
			case (cfg_index)
				sdspi_pkg::CfgRespLimit: resp_limit_q <= cfg_data[7:0];
				sdspi_pkg::CfgBusyLimit: busy_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	sdspi_step u_step (
		.cur           (state_q),
		.cmd           (cmd),
		.command_index (command_index),
		.argument      (argument),
		.rx_byte       (rx_byte),
		.resp_limit    (resp_limit_q),
		.busy_limit    (busy_limit_q),
		.nxt           (state_nxt),
		.res           (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{
				phase: sdspi_pkg::PH_IDLE, byte_pos: 3'd0, wait_count: 20'd0,
				active_cmd: 5'd0, arg: 32'd0, first_status: 8'd0,
				second_status: 8'd0, payload: 32'd0, sel_held: 1'b0
			};
			res_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				state_q <= state_nxt;
			end
			if (in_fire) begin
				res_valid_q <= 1'b1;
			end else if (out_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result payload needs no reset
	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid     = res_valid_q;
	assign tx_valid      = res_q.tx_valid;
	assign tx_byte       = res_q.tx_byte;
	assign chip_select   = res_q.chip_select;
	assign done_res      = res_q.done_res;
	assign status_first  = res_q.status_first;
	assign status_second = res_q.status_second;
	assign payload       = res_q.payload;
	assign busy_res      = res_q.busy_res;

`ifndef SYNTHESIS
	// a completed command always leaves the engine idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res && !tx_valid)
		else $error("done transaction reports engine still busy");

	// idle bus byte whenever nothing is to be exchanged
	a_idle_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tx_valid |-> tx_byte == sdspi_pkg::IdleByte)
		else $error("non-idle byte while no exchange pending");

	// a stalled result blocks further input
	a_stall_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result transaction stalled");
`endif

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SD SPI command engine: a queue-fed driver plays
// card-side byte exchanges, a predictor works out every result, and a monitor
// compares each output transaction field by field under random back-pressure.
// ----------------------------------------------------------------------------

module tb_top;

	localparam int StallLimit = 4000;

	localparam logic [5:0] CmdCode [0:19] = '{
		6'd0, 6'd1, 6'd8, 6'd9, 6'd10, 6'd12, 6'd13, 6'd16, 6'd17, 6'd18,
		6'd23, 6'd24, 6'd25, 6'd32, 6'd33, 6'd38, 6'd41, 6'd55, 6'd58, 6'd59
	};
	localparam logic [7:0] CmdCrc [0:19] = '{
		8'h95, 8'hF9, 8'h87, 8'hAF, 8'h1B, 8'hC3, 8'hAF, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hDF, 8'hFF, 8'h73, 8'h25, 8'h25
	};
	localparam sdspi_pkg::rtype_t CmdRtype [0:19] = '{
		sdspi_pkg::RT_R1, sdspi_pkg::RT_R1, sdspi_pkg::RT_R7, sdspi_pkg::RT_R1,
		sdspi_pkg::RT_R1, sdspi_pkg::RT_R1B, sdspi_pkg::RT_R2, sdspi_pkg::RT_R1,
		sdspi_pkg::RT_R1, sdspi_pkg::RT_R1, sdspi_pkg::RT_R1, sdspi_pkg::RT_R1,
		sdspi_pkg::RT_R1, sdspi_pkg::RT_R1, sdspi_pkg::RT_R1, sdspi_pkg::RT_R1B,
		sdspi_pkg::RT_R3, sdspi_pkg::RT_R1, sdspi_pkg::RT_R7, sdspi_pkg::RT_R1
	};
	// bit i set: command i is followed by a data phase, so select is kept
	localparam logic [19:0] CmdData = 20'h01B18;

	typedef struct packed {
		logic        is_exchange;
		logic [4:0]  index;
		logic [31:0] arg;
		logic [7:0]  rx;
	} spi_item_t;

	typedef struct packed {
		sdspi_pkg::phase_t phase;
		logic [2:0]        pos;
		logic [19:0]       wait_cnt;
		logic [4:0]        cmd_idx;
		logic [31:0]       arg;
		logic [7:0]        first_st;
		logic [7:0]        second_st;
		logic [31:0]       resp_word;
		logic              sel;
	} engine_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = sdspi_pkg::CfgRespLimit;
	logic [19:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        cmd = 1'b0;
	logic [4:0]  command_index = '0;
	logic [31:0] argument = '0;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        chip_select;
	logic        done_res;
	logic [7:0]  status_first;
	logic [7:0]  status_second;
	logic [31:0] payload;
	logic        busy_res;

	logic [7:0]             resp_limit_cfg;
	logic [19:0]            busy_limit_cfg;
	engine_state_t          model_state;
	engine_state_t          plan_state;
	spi_item_t              pending_items [$];
	sdspi_pkg::eng_result_t expected_results [$];
	spi_item_t              cur_item;
	sdspi_pkg::eng_result_t exp_r;
	sdspi_pkg::eng_result_t got_r;
	sdspi_pkg::eng_result_t plan_r;
	int                     useful_items = 0;
	int                     mismatches = 0;
	int                     send_gap = 0;
	int                     send_quiet = 0;
	int                     recv_left = 0;
	int                     recv_quiet = 0;
	int                     recv_stall;
	int                     idle_cycles = 0;
	int                     ph;

	sd_spi_command_engine_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .command_index(command_index), .argument(argument), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.tx_valid(tx_valid), .tx_byte(tx_byte), .chip_select(chip_select),
		.done_res(done_res), .status_first(status_first), .status_second(status_second),
		.payload(payload), .busy_res(busy_res)
	);

	always #6 clk = ~clk;

	function automatic sdspi_pkg::cmd_info_t cmd_lookup(input logic [4:0] i);
		sdspi_pkg::cmd_info_t e;
		e.code  = CmdCode[i];
		e.crc   = CmdCrc[i];
		e.rtype = CmdRtype[i];
		e.data  = CmdData[i];
		return e;
	endfunction

	// One exchange or start of the engine; returns the output word after it.
	function automatic void spi_engine_step(inout engine_state_t s, input spi_item_t it,
			output sdspi_pkg::eng_result_t r);
		sdspi_pkg::cmd_info_t e;
		logic fin;
		fin = 1'b0;
		if (!it.is_exchange) begin
			if (it.index < sdspi_pkg::CmdCount) begin
				s.cmd_idx   = it.index;
				s.arg       = it.arg;
				s.phase     = sdspi_pkg::PH_SEND;
				s.pos       = '0;
				s.wait_cnt  = '0;
				s.first_st  = sdspi_pkg::IdleByte;
				s.second_st = '0;
				s.resp_word = '0;
				s.sel       = 1'b1;
			end
		end else if (s.phase != sdspi_pkg::PH_IDLE) begin
			e = cmd_lookup(s.cmd_idx);
			case (s.phase)
				sdspi_pkg::PH_SEND: begin
					if (s.pos < sdspi_pkg::LastSendPos) s.pos = s.pos + 3'd1;
					else begin
						s.pos = '0;
						s.wait_cnt = {12'd0, resp_limit_cfg};
						s.phase = (s.cmd_idx == sdspi_pkg::StopIndex) ?
							sdspi_pkg::PH_DUMMY : sdspi_pkg::PH_POLL;
					end
				end
				sdspi_pkg::PH_DUMMY: s.phase = sdspi_pkg::PH_POLL;
				sdspi_pkg::PH_POLL: begin
					s.first_st = it.rx;
					s.wait_cnt = {12'd0, s.wait_cnt[7:0] - 8'd1};
					if (!(it.rx == sdspi_pkg::IdleByte && s.wait_cnt != 0)) begin
						case (e.rtype)
							sdspi_pkg::RT_R2: s.phase = sdspi_pkg::PH_SECOND;
							sdspi_pkg::RT_R1B: begin
								s.phase = sdspi_pkg::PH_BUSY;
								s.wait_cnt = busy_limit_cfg;
							end
							sdspi_pkg::RT_R3, sdspi_pkg::RT_R7: begin
								s.phase = sdspi_pkg::PH_COLLECT;
								s.pos = '0;
							end
							default: s.phase = sdspi_pkg::PH_TRAIL;
						endcase
					end
				end
				sdspi_pkg::PH_SECOND: begin
					s.second_st = it.rx;
					s.phase = sdspi_pkg::PH_TRAIL;
				end
				sdspi_pkg::PH_BUSY: begin
					s.wait_cnt = s.wait_cnt - 20'd1;
					if (!(it.rx == 8'h00 && s.wait_cnt != 0)) begin
						s.first_st = 8'h00;
						s.phase = sdspi_pkg::PH_TRAIL;
					end
				end
				sdspi_pkg::PH_COLLECT: begin
					s.resp_word = {s.resp_word[23:0], it.rx};
					if (s.pos >= sdspi_pkg::LastCollectPos) begin
						s.pos = '0;
						s.phase = sdspi_pkg::PH_TRAIL;
					end else s.pos = s.pos + 3'd1;
				end
				sdspi_pkg::PH_TRAIL: begin
					s.phase = sdspi_pkg::PH_IDLE;
					s.sel = e.data;
					fin = 1'b1;
				end
				default: s.phase = sdspi_pkg::PH_IDLE;
			endcase
		end
		e = cmd_lookup(s.cmd_idx);
		r.tx_valid = (s.phase != sdspi_pkg::PH_IDLE);
		r.busy_res = (s.phase != sdspi_pkg::PH_IDLE);
		if (s.phase == sdspi_pkg::PH_SEND) begin
			if (s.pos == 3'd0) r.tx_byte = {sdspi_pkg::CmdPrefix, e.code};
			else if (s.pos >= sdspi_pkg::LastSendPos) r.tx_byte = e.crc;
			else r.tx_byte = 8'(s.arg >> (8 * (4 - int'(s.pos))));
		end else r.tx_byte = sdspi_pkg::IdleByte;
		r.chip_select   = s.sel;
		r.done_res      = fin;
		r.status_first  = s.first_st;
		r.status_second = s.second_st;
		r.payload       = s.resp_word;
	endfunction

	// Mostly short gaps, a few long ones, and now and then a quiet stretch.
	function automatic int draw_gap(inout int quiet);
		int r;
		if (quiet > 0) begin
			quiet = quiet - 1;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			quiet = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic push_item(input logic is_ex, input logic [4:0] idx, input logic [31:0] arg,
			input logic [7:0] rx);
		spi_item_t it;
		it.is_exchange = is_ex;
		it.index = idx;
		it.arg = arg;
		it.rx = rx;
		if (!((is_ex && plan_state.phase == sdspi_pkg::PH_IDLE) ||
				(!is_ex && idx >= sdspi_pkg::CmdCount)))
			useful_items++;
		spi_engine_step(plan_state, it, plan_r);
		pending_items.push_back(it);
	endtask

	// Card side of a running command: leading 0xFF polls, response, busy zeros.
	task automatic run_exchanges(input int ff, input logic [7:0] resp, input int zeros,
			input int cut);
		int n;
		int ff_sent;
		int z_sent;
		logic [7:0] rx;
		n = 0;
		ff_sent = 0;
		z_sent = 0;
		while (plan_state.phase != sdspi_pkg::PH_IDLE && n < cut) begin
			case (plan_state.phase)
				sdspi_pkg::PH_POLL: begin
					if (ff_sent < ff) begin
						rx = sdspi_pkg::IdleByte;
						ff_sent++;
					end else rx = resp;
				end
				sdspi_pkg::PH_BUSY: begin
					if (z_sent < zeros) begin
						rx = 8'h00;
						z_sent++;
					end else rx = 8'($urandom_range(1, 255));
				end
				default: rx = 8'($urandom);
			endcase
			push_item(1'b1, 5'($urandom), $urandom, rx);
			n++;
		end
	endtask

	task automatic plan_command(input logic [4:0] idx, input logic [31:0] arg, input int ff,
			input logic [7:0] resp, input int zeros, input int cut);
		push_item(1'b0, idx, arg, 8'($urandom));
		run_exchanges(ff, resp, zeros, cut);
	endtask

	task automatic random_traffic(input int target);
		int goal;
		int r;
		int ff;
		int zeros;
		int cut;
		logic [7:0] resp;
		goal = useful_items + target;
		while (useful_items < goal) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				ff = ($urandom_range(0, 29) == 0) ? 300 : $urandom_range(0, 3);
				resp = $urandom_range(0, 1) ? 8'($urandom_range(0, 1)) :
					8'($urandom_range(0, 254));
				zeros = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
					$urandom_range(0, 4);
				cut = ($urandom_range(0, 14) == 0) ? $urandom_range(1, 10) : 1000;
				plan_command(5'($urandom_range(0, 19)), $urandom, ff, resp, zeros, cut);
			end else if (r < 88) push_item(1'b1, 5'($urandom), $urandom, 8'($urandom));
			else if (r < 94) push_item(1'b0, 5'($urandom_range(20, 31)), $urandom, 8'($urandom));
			else push_item(1'($urandom_range(0, 1)), 5'($urandom), $urandom, 8'($urandom));
		end
	endtask

	task automatic drain();
		@(negedge clk);
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_limits(input logic [7:0] resp, input logic [19:0] busy);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= sdspi_pkg::CfgRespLimit;
		cfg_data <= {12'd0, resp};
		resp_limit_cfg = resp;
		@(posedge clk);
		cfg_index <= sdspi_pkg::CfgBusyLimit;
		cfg_data <= busy;
		busy_limit_cfg = busy;
		@(posedge clk);
		cfg_we <= 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %0h, got %0h", name, want, got);
		end
	endtask

	// driver: one transaction per free slot, random gaps between them
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			spi_engine_step(model_state, cur_item, exp_r);
			expected_results.push_back(exp_r);
		end
		if (!in_valid || in_ready) begin
			if (send_gap > 0 || pending_items.size() == 0) begin
				in_valid <= 1'b0;
				if (send_gap > 0) send_gap <= send_gap - 1;
			end else begin
				cur_item = pending_items.pop_front();
				cmd <= cur_item.is_exchange;
				command_index <= cur_item.index;
				argument <= cur_item.arg;
				rx_byte <= cur_item.rx;
				in_valid <= 1'b1;
				send_gap <= draw_gap(send_quiet);
			end
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		if (recv_left > 0) recv_left <= recv_left - 1;
		else if (out_ready) begin
			recv_stall = draw_gap(recv_quiet);
			if (recv_stall > 0) begin
				out_ready <= 1'b0;
				recv_left <= recv_stall - 1;
			end else recv_left <= $urandom_range(0, 6);
		end else begin
			out_ready <= 1'b1;
			recv_left <= $urandom_range(0, 12);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			got_r.tx_valid      = tx_valid;
			got_r.tx_byte       = tx_byte;
			got_r.chip_select   = chip_select;
			got_r.done_res      = done_res;
			got_r.status_first  = status_first;
			got_r.status_second = status_second;
			got_r.payload       = payload;
			got_r.busy_res      = busy_res;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transaction: %0h", got_r);
			end else begin
				exp_r = expected_results.pop_front();
				check_field("tx_valid", 32'(exp_r.tx_valid), 32'(got_r.tx_valid));
				check_field("tx_byte", 32'(exp_r.tx_byte), 32'(got_r.tx_byte));
				check_field("chip_select", 32'(exp_r.chip_select), 32'(got_r.chip_select));
				check_field("done_res", 32'(exp_r.done_res), 32'(got_r.done_res));
				check_field("status_first", 32'(exp_r.status_first), 32'(got_r.status_first));
				check_field("status_second", 32'(exp_r.status_second),
					32'(got_r.status_second));
				check_field("payload", exp_r.payload, got_r.payload);
				check_field("busy_res", 32'(exp_r.busy_res), 32'(got_r.busy_res));
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else if (idle_cycles >= StallLimit) begin
			$display("watchdog: no transaction for %0d cycles", idle_cycles);
			$display("status: fail");
			$finish;
		end else idle_cycles <= idle_cycles + 1;
	end

	initial begin
		resp_limit_cfg = sdspi_pkg::RespLimitReset;
		busy_limit_cfg = sdspi_pkg::BusyLimitReset;
		model_state = '0;
		model_state.phase = sdspi_pkg::PH_IDLE;
		plan_state = model_state;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: idle exchange, bad indexes, abandoned command, stop with busy,
		// card that never answers
		push_item(1'b1, 5'd0, 32'h0, 8'h00);
		push_item(1'b0, 5'd31, 32'hFFFF_FFFF, 8'hFF);
		push_item(1'b0, 5'd20, 32'h0, 8'h00);
		plan_command(5'd6, 32'hFFFF_FFFF, 0, 8'h00, 0, 4);
		plan_command(sdspi_pkg::StopIndex, 32'h0000_0000, 1, 8'hFE, 2, 1000);
		plan_command(5'd0, 32'h0000_0000, 300, 8'h00, 0, 1000);
		random_traffic(60);

		for (ph = 1; ph < 7; ph++) begin
			run_exchanges(0, 8'h00, 0, 1000);
			drain();
			case (ph)
				1: write_limits(8'd8, 20'd1);
				2: write_limits(8'd255, 20'hFFFFF);
				3: write_limits(8'd0, 20'd0);
				4: write_limits(8'($urandom_range(8, 40)), 20'($urandom_range(1, 12)));
				5: write_limits(8'($urandom_range(8, 255)), 20'($urandom_range(1, 20'hFFFFF)));
				default: write_limits(sdspi_pkg::RespLimitReset, 20'd3);
			endcase
			random_traffic(35);
			// sender holds off until every result is back
			drain();
			random_traffic(35);
		end

		drain();
		repeat (8) @(negedge clk);
		if (mismatches == 0 && expected_results.size() == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule

[sim.f]
hdl/sdspi_pkg.sv
hdl/sdspi_step.sv
hdl/sd_spi_command_engine_top.sv
dv/tb_top.sv
